>>> src/qrs_pkg.sv
// shared constants, codes and types for the quadratic root solver
`default_nettype none

package qrs_pkg;

  // number format of coefficients and roots
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int THR_W  = 16;
  localparam int CNT_W  = 2;

  // full product and discriminant, discriminant kept signed with headroom
  localparam int PROD_W = 2 * DATA_W;
  localparam int DISC_W = PROD_W + 3;

  // square root input covers |a|*|c| scaled by 2^(2*FRAC_W)
  localparam int RAD_W  = PROD_W + 2 * FRAC_W;
  localparam int ROOT_W = RAD_W / 2;

  // -b +/- sqrt(disc) as a signed sum, then scaled by one half in Q format
  localparam int TSUM_W = DATA_W + 4;
  localparam int NUM_W  = TSUM_W + FRAC_W - 2;

  // digits resolved per pipeline stage
  localparam int SQRT_STEPS  = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_STAGES  = NUM_W / DIV_STEPS;

  // root count codes
  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;
  localparam logic [CNT_W-1:0] CNT_INF  = 2'd3;

  // kind of equation found by the front end
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_INF,
    MODE_LIN,
    MODE_ZERO,
    MODE_SQ,
    MODE_ONE,
    MODE_TWO
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] mag_c;
    logic              sign_a;
    logic              sign_b;
    logic              sign_c;
  } coef_info_t;

  typedef struct packed {
    mode_e mode;
    logic  neg;
  } lane_info_t;

endpackage

`default_nettype wire

>>> src/qrs_cfg_if.sv
// configuration write channel carrying the zero threshold
`default_nettype none

interface qrs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [qrs_pkg::THR_W-1:0]    zero_threshold;

  modport source (output valid, output zero_threshold, input ready);
  modport sink (input valid, input zero_threshold, output ready);
endinterface

`default_nettype wire

>>> src/qrs_coef_if.sv
// coefficient input channel
`default_nettype none

interface qrs_coef_if;
  logic                               valid;
  logic                               ready;
  logic signed [qrs_pkg::DATA_W-1:0]  coef_a;
  logic signed [qrs_pkg::DATA_W-1:0]  coef_b;
  logic signed [qrs_pkg::DATA_W-1:0]  coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

`default_nettype wire

>>> src/qrs_root_if.sv
// root result channel
`default_nettype none

interface qrs_root_if;
  logic                               valid;
  logic                               ready;
  logic [qrs_pkg::CNT_W-1:0]          root_count;
  logic signed [qrs_pkg::DATA_W-1:0]  root_one;
  logic signed [qrs_pkg::DATA_W-1:0]  root_two;
  logic                               overflow;

  modport source (output valid, output root_count, output root_one, output root_two,
                  output overflow, input ready);
  modport sink (input valid, input root_count, input root_one, input root_two,
                input overflow, output ready);
endinterface

`default_nettype wire

>>> src/qrs_front.sv
// front stages: magnitudes, zero tests, products, discriminant and case decode
`default_nettype none

module qrs_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [qrs_pkg::DATA_W-1:0] coef_a_i,
  input  logic signed [qrs_pkg::DATA_W-1:0] coef_b_i,
  input  logic signed [qrs_pkg::DATA_W-1:0] coef_c_i,
  input  logic [qrs_pkg::THR_W-1:0]         thr_i,
  output logic                              valid_o,
  output qrs_pkg::coef_info_t               info_o,
  output logic [qrs_pkg::RAD_W-1:0]         rad_o
);
  import qrs_pkg::*;

  function automatic logic [DATA_W-1:0] abs_val(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // stage 1 signals
  logic [THR_W-1:0]  thr_eff;
  logic [DATA_W-1:0] mag_a, mag_b, mag_c, thr_ext;
  logic              v1_q, sa1_q, sb1_q, sc1_q, za1_q, zb1_q, zc1_q;
  logic [DATA_W-1:0] ma1_q, mb1_q, mc1_q;
  logic [THR_W-1:0]  thr1_q;

  // stage 2 signals
  logic [PROD_W-1:0] b2_d, p_d;
  logic              v2_q, sa2_q, sb2_q, sc2_q, za2_q, zb2_q, zc2_q;
  logic [DATA_W-1:0] ma2_q, mb2_q, mc2_q;
  logic [THR_W-1:0]  thr2_q;
  logic [PROD_W-1:0] b2_q, p_q;

  // stage 3 signals
  logic [DISC_W-1:0] b2x, p4x, disc, disc_abs;
  logic [DISC_W-2:0] disc_mag, thr_disc;
  logic              disc_neg, disc_near;
  mode_e             mode_d;
  logic [RAD_W-1:0]  rad_d;
  logic              v3_q;
  coef_info_t        info3_q;
  logic [RAD_W-1:0]  rad3_q;

  // magnitudes and zero tests; a zero threshold acts as one
  assign thr_eff = (thr_i == '0) ? THR_W'(1) : thr_i;
  assign thr_ext = {{(DATA_W-THR_W){1'b0}}, thr_eff};
  assign mag_a   = abs_val(coef_a_i);
  assign mag_b   = abs_val(coef_b_i);
  assign mag_c   = abs_val(coef_c_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma1_q  <= mag_a;
      mb1_q  <= mag_b;
      mc1_q  <= mag_c;
      sa1_q  <= coef_a_i[DATA_W-1];
      sb1_q  <= coef_b_i[DATA_W-1];
      sc1_q  <= coef_c_i[DATA_W-1];
      za1_q  <= mag_a < thr_ext;
      zb1_q  <= mag_b < thr_ext;
      zc1_q  <= mag_c < thr_ext;
      thr1_q <= thr_eff;
    end
  end

  // b squared and |a|*|c|
  assign b2_d = mb1_q * mb1_q;
  assign p_d  = ma1_q * mc1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_q   <= b2_d;
      p_q    <= p_d;
      ma2_q  <= ma1_q;
      mb2_q  <= mb1_q;
      mc2_q  <= mc1_q;
      sa2_q  <= sa1_q;
      sb2_q  <= sb1_q;
      sc2_q  <= sc1_q;
      za2_q  <= za1_q;
      zb2_q  <= zb1_q;
      zc2_q  <= zc1_q;
      thr2_q <= thr1_q;
    end
  end

  // discriminant b*b - 4ac, exact
  assign b2x       = {3'b000, b2_q};
  assign p4x       = {1'b0, p_q, 2'b00};
  assign disc      = (sa2_q ^ sc2_q) ? (b2x + p4x) : (b2x - p4x);
  assign disc_neg  = disc[DISC_W-1];
  assign disc_abs  = disc_neg ? (~disc + 1'b1) : disc;
  assign disc_mag  = disc_abs[DISC_W-2:0];
  assign thr_disc  = (DISC_W-1)'(thr2_q) << FRAC_W;
  assign disc_near = disc_mag < thr_disc;

  // case decode
  always_comb begin
    mode_d = MODE_NONE;
    if (za2_q) begin
      if (zb2_q) begin
        mode_d = zc2_q ? MODE_INF : MODE_NONE;
      end else begin
        mode_d = MODE_LIN;
      end
    end else if (zb2_q) begin
      if (zc2_q) begin
        mode_d = MODE_ZERO;
      end else if (sa2_q != sc2_q) begin
        mode_d = MODE_SQ;
      end
    end else if (disc_near) begin
      mode_d = MODE_ONE;
    end else if (!disc_neg) begin
      mode_d = MODE_TWO;
    end
  end

  // radicand: |a|*|c| scaled for the b = 0 form, the discriminant for two roots, else zero
  always_comb begin
    case (mode_d)
      MODE_SQ:  rad_d = {p_q, {(2*FRAC_W){1'b0}}};
      MODE_TWO: rad_d = RAD_W'(disc_mag);
      default:  rad_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      info3_q.mode   <= mode_d;
      info3_q.mag_a  <= ma2_q;
      info3_q.mag_b  <= mb2_q;
      info3_q.mag_c  <= mc2_q;
      info3_q.sign_a <= sa2_q;
      info3_q.sign_b <= sb2_q;
      info3_q.sign_c <= sc2_q;
      rad3_q         <= rad_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign info_o  = info3_q;
  assign rad_o   = rad3_q;

endmodule

`default_nettype wire

>>> src/qrs_sqrt.sv
// pipelined integer square root, floor of the exact root
`default_nettype none

module qrs_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [qrs_pkg::RAD_W-1:0]    rad_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic [qrs_pkg::ROOT_W-1:0]   root_o,
  output logic [SIDE_W-1:0]            side_o
);
  import qrs_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [SIDE_W-1:0] side_q [SQRT_STAGES];
  logic              valid_q [SQRT_STAGES];

  logic [RAD_W-1:0]  rad_d  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_d  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_d [SQRT_STAGES];

  // two root digits per stage
  always_comb begin
    logic [RAD_W-1:0]  r;
    logic [REM_W-1:0]  m, mn, tr;
    logic [ROOT_W-1:0] t;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        r = rad_i;
        m = '0;
        t = '0;
      end else begin
        r = rad_q[s-1];
        m = rem_q[s-1];
        t = root_q[s-1];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        mn = {m[REM_W-3:0], r[RAD_W-1 -: 2]};
        tr = {{(REM_W-ROOT_W-2){1'b0}}, t, 2'b01};
        if (mn >= tr) begin
          m = mn - tr;
          t = {t[ROOT_W-2:0], 1'b1};
        end else begin
          m = mn;
          t = {t[ROOT_W-2:0], 1'b0};
        end
        r = r << 2;
      end
      rad_d[s]  = r;
      rem_d[s]  = m;
      root_d[s] = t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        rad_q[s]  <= rad_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        valid_q[s] <= (s == 0) ? valid_i : valid_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[SQRT_STAGES-1];
  assign root_o  = root_q[SQRT_STAGES-1];
  assign side_o  = side_q[SQRT_STAGES-1];

endmodule

`default_nettype wire

>>> src/qrs_div.sv
// pipelined restoring divider on magnitudes, quotient truncated
`default_nettype none

module qrs_div #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [qrs_pkg::NUM_W-1:0]   num_i,
  input  logic [qrs_pkg::DATA_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [qrs_pkg::NUM_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]           side_o
);
  import qrs_pkg::*;

  // numerator shifts out at the top while quotient bits shift in below
  logic [NUM_W-1:0]  nq_q  [DIV_STAGES];
  logic [DATA_W-1:0] rem_q [DIV_STAGES];
  logic [DATA_W-1:0] den_q [DIV_STAGES];
  logic [SIDE_W-1:0] side_q [DIV_STAGES];
  logic              valid_q [DIV_STAGES];

  logic [NUM_W-1:0]  nq_d  [DIV_STAGES];
  logic [DATA_W-1:0] rem_d [DIV_STAGES];

  // two quotient bits per stage
  always_comb begin
    logic [NUM_W-1:0]  n;
    logic [DATA_W-1:0] m, d;
    logic [DATA_W:0]   rn;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        n = num_i;
        m = '0;
        d = den_i;
      end else begin
        n = nq_q[s-1];
        m = rem_q[s-1];
        d = den_q[s-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        rn = {m, n[NUM_W-1]};
        n  = n << 1;
        if (rn >= {1'b0, d}) begin
          rn   = rn - {1'b0, d};
          n[0] = 1'b1;
        end
        m = rn[DATA_W-1:0];
      end
      nq_d[s]  = n;
      rem_d[s] = m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        nq_q[s]   <= nq_d[s];
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= (s == 0) ? den_i : den_q[s-1];
        side_q[s] <= (s == 0) ? side_i : side_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        valid_q[s] <= (s == 0) ? valid_i : valid_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign quo_o   = nq_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> src/qrs_back.sv
// back end: sign, saturation, root ordering and the output register
`default_nettype none

module qrs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  qrs_pkg::lane_info_t         info_i,
  input  logic                        neg_y_i,
  input  logic [qrs_pkg::NUM_W-1:0]   quo_x_i,
  input  logic [qrs_pkg::NUM_W-1:0]   quo_y_i,
  output logic                        en_o,
  qrs_root_if.source                  root_o
);
  import qrs_pkg::*;

  // returns {overflow, value}
  function automatic logic [DATA_W:0] saturate(input logic [NUM_W-1:0] q, input logic neg);
    logic ovf;
    logic [DATA_W-1:0] v;
    if (neg) begin
      ovf = (|q[NUM_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]));
      v   = ovf ? {1'b1, {(DATA_W-1){1'b0}}} : (~q[DATA_W-1:0] + 1'b1);
    end else begin
      ovf = |q[NUM_W-1:DATA_W-1];
      v   = ovf ? {1'b0, {(DATA_W-1){1'b1}}} : q[DATA_W-1:0];
    end
    return {ovf, v};
  endfunction

  logic [DATA_W:0]   sat_x, sat_y;
  logic [DATA_W-1:0] x, y, big, lit;
  logic [CNT_W-1:0]  count_d;
  logic              valid_q, ovf_q;
  logic [CNT_W-1:0]  count_q;
  logic [DATA_W-1:0] one_q, two_q;

  assign sat_x = saturate(quo_x_i, info_i.neg);
  assign sat_y = saturate(quo_y_i, neg_y_i);
  assign x     = sat_x[DATA_W-1:0];
  assign y     = sat_y[DATA_W-1:0];
  assign big   = ($signed(x) > $signed(y)) ? x : y;
  assign lit   = ($signed(x) > $signed(y)) ? y : x;

  // root count per case
  always_comb begin
    case (info_i.mode)
      MODE_NONE: count_d = CNT_NONE;
      MODE_INF:  count_d = CNT_INF;
      MODE_LIN:  count_d = CNT_ONE;
      MODE_ZERO: count_d = CNT_ONE;
      MODE_ONE:  count_d = CNT_ONE;
      MODE_SQ:   count_d = CNT_TWO;
      MODE_TWO:  count_d = CNT_TWO;
      default:   count_d = CNT_NONE;
    endcase
  end

  // pipeline advances whenever the output register is free or being taken
  assign en_o = !valid_q || root_o.ready;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      count_q <= count_d;
      if (count_d == CNT_NONE || count_d == CNT_INF) begin
        one_q <= '0;
        two_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        one_q <= big;
        two_q <= lit;
        ovf_q <= sat_x[DATA_W] | sat_y[DATA_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  assign root_o.valid      = valid_q;
  assign root_o.root_count = count_q;
  assign root_o.root_one   = one_q;
  assign root_o.root_two   = two_q;
  assign root_o.overflow   = ovf_q;

endmodule

`default_nettype wire

>>> src/quadratic_root_solver_top.sv
// top level of the pipelined quadratic root solver
`default_nettype none

// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients and returns the
// number of real roots and the roots, larger first. One coefficient set is
// accepted every clock cycle unless the pipeline stalls. Each result passes
// through 54 register stages: three front stages (magnitudes, products,
// discriminant), 24 square root stages at two root bits each, one lane select
// stage, 25 divider stages at two quotient bits each and the output register.
// The whole pipeline stalls as one while a result waits on the output, so
// nothing is dropped or repeated. The zero threshold may only be written while
// no item is in flight; it resets to 1 and a value of 0 acts as 1.
module quadratic_root_solver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  qrs_cfg_if.sink     cfg_i,
  qrs_coef_if.sink    coef_i,
  qrs_root_if.source  root_o
);
  import qrs_pkg::*;

  logic              en;
  logic [THR_W-1:0]  thr_q;

  logic              front_valid;
  coef_info_t        front_info;
  logic [RAD_W-1:0]  front_rad;

  logic              sqrt_valid;
  logic [ROOT_W-1:0] sqrt_root;
  logic [$bits(coef_info_t)-1:0] sqrt_side;
  coef_info_t        info;

  logic signed [TSUM_W-1:0] neg_b, root_s, t1, t2;
  logic [TSUM_W-1:0] t1_abs, t2_abs;
  logic [NUM_W-1:0]  num_x_d, num_y_d;
  logic [DATA_W-1:0] den_d;
  logic              neg_x_d, neg_y_d;

  logic              sel_valid_q;
  logic [NUM_W-1:0]  num_x_q, num_y_q;
  logic [DATA_W-1:0] den_q;
  lane_info_t        lane_x_q;
  logic              neg_y_q;

  logic              div_x_valid, div_y_valid;
  logic [NUM_W-1:0]  quo_x, quo_y;
  logic [$bits(lane_info_t)-1:0] div_x_side;
  logic              div_y_side;

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      thr_q <= cfg_i.zero_threshold;
    end
  end

  assign coef_i.ready = en;

  qrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (coef_i.valid),
    .coef_a_i (coef_i.coef_a),
    .coef_b_i (coef_i.coef_b),
    .coef_c_i (coef_i.coef_c),
    .thr_i    (thr_q),
    .valid_o  (front_valid),
    .info_o   (front_info),
    .rad_o    (front_rad)
  );

  qrs_sqrt #(
    .SIDE_W ($bits(coef_info_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .rad_i   (front_rad),
    .side_i  (front_info),
    .valid_o (sqrt_valid),
    .root_o  (sqrt_root),
    .side_o  (sqrt_side)
  );

  assign info = coef_info_t'(sqrt_side);

  // -b +/- sqrt(disc) for the two-root case
  assign neg_b  = info.sign_b ? TSUM_W'(info.mag_b) : -TSUM_W'(info.mag_b);
  assign root_s = TSUM_W'(sqrt_root);
  assign t1     = neg_b + root_s;
  assign t2     = neg_b - root_s;
  assign t1_abs = t1[TSUM_W-1] ? (~t1 + 1'b1) : t1;
  assign t2_abs = t2[TSUM_W-1] ? (~t2 + 1'b1) : t2;

  // numerator, divisor and sign of each divider lane
  always_comb begin
    num_x_d = '0;
    num_y_d = '0;
    den_d   = DATA_W'(1);
    neg_x_d = 1'b0;
    neg_y_d = 1'b0;
    case (info.mode)
      MODE_LIN: begin
        num_x_d = NUM_W'({info.mag_c, {FRAC_W{1'b0}}});
        num_y_d = num_x_d;
        den_d   = info.mag_b;
        neg_x_d = !info.sign_c ^ info.sign_b;
        neg_y_d = neg_x_d;
      end
      MODE_SQ: begin
        num_x_d = NUM_W'(sqrt_root);
        num_y_d = num_x_d;
        den_d   = info.mag_a;
        neg_y_d = 1'b1;
      end
      MODE_ZERO: begin
        den_d = info.mag_a;
      end
      MODE_ONE: begin
        num_x_d = NUM_W'({info.mag_b, {(FRAC_W-1){1'b0}}});
        num_y_d = num_x_d;
        den_d   = info.mag_a;
        neg_x_d = !info.sign_b ^ info.sign_a;
        neg_y_d = neg_x_d;
      end
      MODE_TWO: begin
        num_x_d = {t1_abs[TSUM_W-2:0], {(FRAC_W-1){1'b0}}};
        num_y_d = {t2_abs[TSUM_W-2:0], {(FRAC_W-1){1'b0}}};
        den_d   = info.mag_a;
        neg_x_d = t1[TSUM_W-1] ^ info.sign_a;
        neg_y_d = t2[TSUM_W-1] ^ info.sign_a;
      end
      default: begin
        num_x_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_x_q       <= num_x_d;
      num_y_q       <= num_y_d;
      den_q         <= den_d;
      lane_x_q.mode <= info.mode;
      lane_x_q.neg  <= neg_x_d;
      neg_y_q       <= neg_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_valid_q <= 1'b0;
    end else if (en) begin
      sel_valid_q <= sqrt_valid;
    end
  end

  qrs_div #(
    .SIDE_W ($bits(lane_info_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sel_valid_q),
    .num_i   (num_x_q),
    .den_i   (den_q),
    .side_i  (lane_x_q),
    .valid_o (div_x_valid),
    .quo_o   (quo_x),
    .side_o  (div_x_side)
  );

  qrs_div #(
    .SIDE_W (1)
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sel_valid_q),
    .num_i   (num_y_q),
    .den_i   (den_q),
    .side_i  (neg_y_q),
    .valid_o (div_y_valid),
    .quo_o   (quo_y),
    .side_o  (div_y_side)
  );

  qrs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_x_valid),
    .info_i  (lane_info_t'(div_x_side)),
    .neg_y_i (div_y_side),
    .quo_x_i (quo_x),
    .quo_y_i (quo_y),
    .en_o    (en),
    .root_o  (root_o)
  );

  // both divider lanes carry the same items
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_x_valid == div_y_valid)
    else $error("divider lanes out of step");

  // no roots or infinitely many roots carry zero values and no overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid && (root_o.root_count == CNT_NONE || root_o.root_count == CNT_INF)
    |-> root_o.root_one == '0 && root_o.root_two == '0 && !root_o.overflow)
    else $error("nonzero roots without finite root set");

  // a single root is copied into both outputs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid && root_o.root_count == CNT_ONE |-> root_o.root_one == root_o.root_two)
    else $error("single root not copied");

  // two roots come larger first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid && root_o.root_count == CNT_TWO
    |-> $signed(root_o.root_one) >= $signed(root_o.root_two))
    else $error("roots out of order");

endmodule

`default_nettype wire
